// ----- sv/tdp_pkg.sv -----
// Package: widths and state encoding for the trial-division primality tester.
`timescale 1ns / 1ps
package tdp_pkg;

  localparam int CAND_WIDTH  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int NW  = (VALUE_WIDTH < CAND_WIDTH) ? VALUE_WIDTH : CAND_WIDTH;
  localparam int DW  = (NW + 1) / 2 + 2;
  localparam int SQW = NW + 2;
  localparam int CW  = $clog2(NW + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_BOUND,
    S_DIV,
    S_EVAL,
    S_FINISH
  } state_t;

endpackage

// ----- sv/tdp_in_if.sv -----
// Interface: candidate request channel.
`timescale 1ns / 1ps
interface tdp_in_if import tdp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CAND_WIDTH-1:0] candidate;

  modport source (output valid, output candidate, input ready);
  modport sink   (input valid, input candidate, output ready);
endinterface

// ----- sv/tdp_out_if.sv -----
// Interface: primality result channel.
`timescale 1ns / 1ps
interface tdp_out_if import tdp_pkg::*; ();
  logic valid;
  logic ready;
  logic is_prime;

  modport source (output valid, output is_prime, input ready);
  modport sink   (input valid, input is_prime, output ready);
endinterface

// ----- sv/trial_division_primality_test.sv -----
// Top level: trial-division primality tester with a bit-serial remainder unit.
`timescale 1ns / 1ps
// One candidate is processed at a time. Zero, one, two and even candidates
// are decided in the check state, with no divisor tried. An odd candidate of
// 3 or more runs one remainder pass for each odd divisor tried (up to about
// 2^(NW/2 - 1), roughly 32768 for 32-bit values). The run length is set by
// the restoring remainder unit, which retires one bit of the candidate per
// cycle for each divisor. The result sits in an output register, so a new
// request is taken while the previous answer still waits to be read.
module trial_division_primality_test import tdp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  tdp_in_if.sink    in_ch,
  tdp_out_if.source out_ch
);

  state_t          state_r, state_nxt;
  logic [NW-1:0]   n_r, n_nxt;
  logic [NW-1:0]   nsh_r, nsh_nxt;
  logic [DW-1:0]   d_r, d_nxt;
  logic [SQW-1:0]  sq_r, sq_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_prime_r, out_prime_nxt;

  logic            in_acc;
  logic            out_free;
  logic [DW:0]     trial;
  logic            ge;
  logic            bound_over;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_r || out_ch.ready;
  assign trial      = {rem_r, nsh_r[NW-1]};
  assign ge         = trial >= {1'b0, d_r};
  assign bound_over = sq_r > {{(SQW-NW){1'b0}}, n_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_CHECK;
      S_CHECK: begin
        if (n_r < NW'(2) || n_r == NW'(2) || !n_r[0]) state_nxt = S_FINISH;
        else state_nxt = S_BOUND;
      end
      S_BOUND:  state_nxt = bound_over ? S_FINISH : S_DIV;
      S_DIV:    if (cnt_r == CW'(1)) state_nxt = S_EVAL;
      S_EVAL:   state_nxt = (rem_r == '0) ? S_FINISH : S_BOUND;
      S_FINISH: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready   = (state_r == S_IDLE);
    n_nxt         = n_r;
    nsh_nxt       = nsh_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_prime_nxt = out_prime_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) n_nxt = in_ch.candidate[NW-1:0];
      end
      S_CHECK: begin
        res_nxt = (n_r == NW'(2));
        d_nxt   = DW'(3);
        sq_nxt  = SQW'(9);
      end
      S_BOUND: begin
        res_nxt = 1'b1;
        nsh_nxt = n_r;
        rem_nxt = '0;
        cnt_nxt = CW'(NW);
      end
      S_DIV: begin
        rem_nxt = ge ? DW'(trial - {1'b0, d_r}) : trial[DW-1:0];
        nsh_nxt = {nsh_r[NW-2:0], 1'b0};
        cnt_nxt = cnt_r - CW'(1);
      end
      S_EVAL: begin
        res_nxt = 1'b0;
        d_nxt   = d_r + DW'(2);
        sq_nxt  = sq_r + {{(SQW-DW-2){1'b0}}, d_r, 2'b00} + SQW'(4);
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = res_r;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.is_prime = out_prime_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    nsh_r       <= nsh_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    res_r       <= res_nxt;
    out_prime_r <= out_prime_nxt;
  end

  a_accept_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == S_CHECK)
    else $error("accepted request did not enter check");

  a_two_prime: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && n_r == NW'(2)) |=> (state_r == S_FINISH && res_r))
    else $error("candidate two not reported prime");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < d_r && d_r[0]))
    else $error("partial remainder out of range or even divisor");

  a_finish_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_free) |=> (out_valid_r && out_prime_r == $past(res_r)))
    else $error("result not loaded into output register");

endmodule

// ----- tb/trial_division_primality_test_tb.sv -----
// Testbench: trial-division primality tester, table-driven probes then random candidates.
`timescale 1ns / 1ps
module trial_division_primality_test_tb;
  import tdp_pkg::*;

  localparam int RAND_ITEMS   = 100;
  localparam int HOLD_CYCLES  = 40000;
  localparam int DRAIN_CYCLES = 20;
  localparam int IDLE_LIMIT   = 300000;
  localparam int NUM_PROBES   = 18;

  typedef struct {
    logic [CAND_WIDTH-1:0] cand;
    bit                    typed;
    bit                    prime;
  } probe_t;

  typedef struct {
    logic [CAND_WIDTH-1:0] cand;
    bit                    prime;
  } verdict_t;

  logic clk;
  logic rst_n;
  logic row_typed;
  logic row_prime;

  verdict_t verdict_q[$];
  verdict_t head;
  probe_t   probes [NUM_PROBES];
  int       mismatches;
  int       idle_cycles;
  bit       hold_off_req;

  tdp_in_if  in_ch ();
  tdp_out_if out_ch ();

  trial_division_primality_test dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit primality_of(logic [CAND_WIDTH-1:0] c);
    bit [63:0] n;
    bit [63:0] d;
    n = 64'(c);
    if (NW < 64) n = n & ((64'd1 << NW) - 64'd1);
    if (n < 64'd2) return 1'b0;
    if (n == 64'd2) return 1'b1;
    if (!n[0]) return 1'b0;
    for (d = 64'd3; d <= n / d; d += 64'd2)
      if (n % d == 64'd0) return 1'b0;
    return 1'b1;
  endfunction

  // Mostly small odd values so the divisor loop runs to the end; wide values carry a
  // factor of two or three so they finish quickly.
  function automatic logic [CAND_WIDTH-1:0] next_candidate();
    logic [CAND_WIDTH-1:0] r;
    int unsigned           pick;
    pick = $urandom_range(0, 99);
    r    = $urandom;
    if (pick < 50) begin
      r = $urandom_range(0, 4095);
      if ($urandom_range(0, 4) != 0) r[0] = 1'b1;
    end else if (pick < 72) begin
      r = $urandom_range(0, 65535);
      if ($urandom_range(0, 4) != 0) r[0] = 1'b1;
    end else if (pick < 82) begin
      r = $urandom_range(0, 1 << 20);
      if ($urandom_range(0, 3) != 0) r[0] = 1'b1;
    end else if (pick < 92) begin
      r = r - r % 3;
    end else begin
      r[0] = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic offer(input logic [CAND_WIDTH-1:0] c, input bit typed, input bit prime);
    if (!in_ch.valid) in_ch.valid <= 1'b1;
    in_ch.candidate <= c;
    row_typed       <= typed;
    row_prime       <= prime;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_sender(input int cycles);
    if (cycles > 0) begin
      in_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // request / result scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        verdict_q.push_back(verdict_t'{cand:  in_ch.candidate,
                                       prime: row_typed ? row_prime
                                                        : primality_of(in_ch.candidate)});
      if (out_ch.valid && out_ch.ready) begin
        if (verdict_q.size() == 0) begin
          report_mismatch($sformatf("is_prime=%0b with no request outstanding",
                                    out_ch.is_prime));
        end else begin
          head = verdict_q.pop_front();
          if (out_ch.is_prime !== head.prime)
            report_mismatch($sformatf("candidate %0d: is_prime=%0b, want %0b",
                                      head.cand, out_ch.is_prime, head.prime));
        end
      end
    end
  end

  // receiver: rotating stall pattern, plus one long hold-off on request
  initial begin
    logic [15:0] stall_pat;
    int          cyc;
    out_ch.ready <= 1'b0;
    stall_pat = 16'hffff;
    cyc       = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        if (cyc % 32 == 0) begin
          case ($urandom_range(0, 3))
            0:       stall_pat = 16'hffff;
            1:       stall_pat = 16'($urandom);
            2:       stall_pat = 16'($urandom | $urandom);
            default: stall_pat = 16'($urandom & $urandom) | 16'h0001;
          endcase
        end
        out_ch.ready <= stall_pat[0];
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        cyc++;
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL trial_division_primality_test");
    $finish;
  end

  initial begin
    int sent;
    int burst;
    bit hold_done;
    mismatches   = 0;
    hold_off_req = 1'b0;
    hold_done    = 1'b0;
    sent         = 0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.candidate <= '0;
    row_typed       <= 1'b0;
    row_prime       <= 1'b0;

    probes = '{
      '{32'd0,          1'b1, 1'b0},
      '{32'd1,          1'b1, 1'b0},
      '{32'd2,          1'b1, 1'b1},
      '{32'd3,          1'b1, 1'b1},
      '{32'd4,          1'b1, 1'b0},
      '{32'hFFFF_FFFE,  1'b1, 1'b0},
      '{32'h8000_0000,  1'b1, 1'b0},
      '{32'hFFFF_FFFF,  1'b0, 1'b0},
      '{32'd5,          1'b0, 1'b0},
      '{32'd9,          1'b0, 1'b0},
      '{32'd25,         1'b0, 1'b0},
      '{32'd49,         1'b0, 1'b0},
      '{32'd63001,      1'b0, 1'b0},  // 251 squared: divisor bound hit exactly
      '{32'd65521,      1'b0, 1'b0},
      '{32'd65535,      1'b0, 1'b0},
      '{32'd1000003,    1'b0, 1'b0},
      '{32'd16777213,   1'b0, 1'b0},
      '{32'h5555_5555,  1'b0, 1'b0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probes[i]) begin
      offer(probes[i].cand, probes[i].typed, probes[i].prime);
      pause_sender($urandom_range(0, 2));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);

    while (sent < RAND_ITEMS) begin
      burst = $urandom_range(1, 10);
      if (!hold_done && sent >= 30) begin
        // receiver blocks while requests keep coming, so the input stalls
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
        burst        = 8;
      end
      for (int i = 0; i < burst && sent < RAND_ITEMS; i++) begin
        offer(next_candidate(), 1'b0, 1'b0);
        sent++;
      end
      pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS trial_division_primality_test");
    else
      $display("FAIL trial_division_primality_test");
    $finish;
  end

endmodule
